// ===== hdl/tat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tat_pkg;

   // Command codes carried in the request word's tuser.
   localparam logic [1:0] CMD_SET      = 2'd0;
   localparam logic [1:0] CMD_LOOKUP   = 2'd1;
   localparam logic [1:0] CMD_NEWFRAME = 2'd2;
   localparam logic [1:0] CMD_NONE     = 2'd3;

   // Play modes stored per tile.
   localparam logic [1:0] MODE_STOPPED = 2'd0;
   localparam logic [1:0] MODE_ONCE    = 2'd1;
   localparam logic [1:0] MODE_LOOP    = 2'd2;

   localparam int TIMER_W = 17;
   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   // One tile's animation record, as held in the state memory.
   typedef struct packed {
      logic [7:0]         frame_limit;
      logic [15:0]        increment;
      logic [15:0]        period;
      logic [TIMER_W-1:0] timer;
      logic [7:0]         offset;
      logic [1:0]         mode;
   } entry_type;

   typedef struct packed {
      logic state_we;
      logic seen_we;
      logic rsp_valid;
   } upd_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/tile_animation_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Per-tile animation table. Each request word carries a command in tuser: set animation
// (one-based tile, no response), look up shown tile (zero-based index, one response word
// with the index plus the tile's current frame offset) or new frame (no response). Tile
// records live in one synchronous state memory and one single-bit "seen this frame"
// memory; a set or lookup passes through the update stage, and a word to the same
// tile may follow in the next cycle because the record just written is forwarded, so set
// and lookup words sustain one per cycle while the response register is drained. A new
// frame word starts a sweep that clears the seen memory one entry a cycle, and the block
// takes no word until the sweep ends. After reset a clearing pass zeroes both memories
// before the first word is accepted.
module tile_animation_table #(
   parameter int TILE_COUNT = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata, from bit 0: tile_number[9], frame_total[8], step_increment[16],
   // frame_period[16], play_once[1], zero fill.
   input  wire logic [tat_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: command[2].
   input  wire logic [1:0]                     req_tuser,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // rsp_tdata, from bit 0: shown_tile[9], zero fill.
   output logic [tat_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready
);

   localparam int AW = $clog2(TILE_COUNT);
   localparam int EW = (AW > 9) ? AW : 9;

   // Fields of the incoming word.
   logic [1:0]  in_command;
   logic [8:0]  in_tile;
   logic [7:0]  in_total;
   logic [15:0] in_increment;
   logic [15:0] in_period;
   logic        in_once;
   logic [8:0]  in_index;
   logic [EW-1:0] in_index_ext;
   logic        in_range;
   logic        accept;

   assign in_command   = req_tuser;
   assign in_tile      = req_tdata[8:0];
   assign in_total     = req_tdata[16:9];
   assign in_increment = req_tdata[32:17];
   assign in_period    = req_tdata[48:33];
   assign in_once      = req_tdata[49];

   // A set names its tile one-based; tile zero is taken as the first tile.
   assign in_index = ((in_command == tat_pkg::CMD_SET) && (in_tile != 9'd0)) ?
                     in_tile - 9'd1 : in_tile;
   assign in_index_ext = EW'(in_index);
   assign in_range     = (32'(in_index) < TILE_COUNT);
   assign accept       = req_tvalid && req_tready;

   // Update stage registers.
   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_command_ff;
   logic [8:0]    s1_tile_ff;
   logic [7:0]    s1_total_ff;
   logic [15:0]   s1_increment_ff;
   logic [15:0]   s1_period_ff;
   logic          s1_once_ff;
   logic          s1_range_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          fwd_state_hit_ff, fwd_state_hit_in;
   tat_pkg::entry_type fwd_state_ff;
   logic          fwd_seen_hit_ff, fwd_seen_hit_in;

   // Memories and their read data.
   tat_pkg::entry_type state_mem_ff [TILE_COUNT];
   logic               seen_mem_ff  [TILE_COUNT];
   tat_pkg::entry_type state_rdata_ff;
   logic               seen_rdata_ff;

   // Clearing sweep.
   logic          sweep_ff, sweep_in;
   logic          sweep_all_ff, sweep_all_in;
   logic [AW-1:0] sweep_cnt_ff, sweep_cnt_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [8:0] rsp_tile_ff;

   tat_pkg::entry_type    entry_cur;
   logic                  seen_cur;
   tat_pkg::entry_type    entry_new;
   tat_pkg::upd_ctrl_type ctrl;
   logic [8:0]            shown_tile;
   logic                  s1_adv;

   logic               state_we;
   logic               seen_we;
   logic [AW-1:0]      wr_addr;
   tat_pkg::entry_type state_wdata;
   logic               seen_wdata;

   // The record written by the word leaving the update stage is newer than what the
   // memory returns for a word read at the same edge.
   assign entry_cur = fwd_state_hit_ff ? fwd_state_ff : state_rdata_ff;
   assign seen_cur  = fwd_seen_hit_ff ? 1'b1 : seen_rdata_ff;

   tat_update u_update (
      .command        (s1_command_ff),
      .tile_number    (s1_tile_ff),
      .frame_total    (s1_total_ff),
      .step_increment (s1_increment_ff),
      .frame_period   (s1_period_ff),
      .play_once      (s1_once_ff),
      .in_range       (s1_range_ff),
      .entry_in       (entry_cur),
      .seen_in        (seen_cur),
      .entry_out      (entry_new),
      .ctrl           (ctrl),
      .shown_tile     (shown_tile)
   );

   // The stage retires unless its response would overwrite one not yet taken.
   assign s1_adv = s1_valid_ff && (!ctrl.rsp_valid || !rsp_valid_ff || rsp_tready);
   assign req_tready = !sweep_ff && (!s1_valid_ff || s1_adv);

   assign s1_valid_in      = accept ? (in_command != tat_pkg::CMD_NEWFRAME) :
                             (s1_valid_ff && !s1_adv);
   assign fwd_state_hit_in = s1_adv && ctrl.state_we && (s1_addr_ff == in_index_ext[AW-1:0]);
   assign fwd_seen_hit_in  = s1_adv && ctrl.seen_we && (s1_addr_ff == in_index_ext[AW-1:0]);

   always_comb begin
      if (sweep_ff) begin
         state_we    = sweep_all_ff;
         seen_we     = 1'b1;
         wr_addr     = sweep_cnt_ff;
         state_wdata = '0;
         seen_wdata  = 1'b0;
      end else begin
         state_we    = s1_adv && ctrl.state_we;
         seen_we     = s1_adv && ctrl.seen_we;
         wr_addr     = s1_addr_ff;
         state_wdata = entry_new;
         seen_wdata  = 1'b1;
      end
   end

   always_comb begin
      sweep_in     = sweep_ff;
      sweep_all_in = sweep_all_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + AW'(1);
         if (sweep_cnt_ff == AW'(TILE_COUNT - 1)) begin
            sweep_in     = 1'b0;
            sweep_all_in = 1'b0;
         end
      end else if (accept && (in_command == tat_pkg::CMD_NEWFRAME)) begin
         sweep_in     = 1'b1;
         sweep_all_in = 1'b0;
         sweep_cnt_in = '0;
      end
   end

   always_comb begin
      if (s1_adv && ctrl.rsp_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sweep_ff     <= 1'b1;
         sweep_all_ff <= 1'b1;
         sweep_cnt_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sweep_ff     <= sweep_in;
         sweep_all_ff <= sweep_all_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_command_ff    <= in_command;
         s1_tile_ff       <= in_index;
         s1_total_ff      <= in_total;
         s1_increment_ff  <= in_increment;
         s1_period_ff     <= in_period;
         s1_once_ff       <= in_once;
         s1_range_ff      <= in_range;
         s1_addr_ff       <= in_index_ext[AW-1:0];
         fwd_state_hit_ff <= fwd_state_hit_in;
         fwd_state_ff     <= entry_new;
         fwd_seen_hit_ff  <= fwd_seen_hit_in;
      end
      if (s1_adv && ctrl.rsp_valid) begin
         rsp_tile_ff <= shown_tile;
      end
   end

   // State memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (state_we) begin
         state_mem_ff[wr_addr] <= state_wdata;
      end
      if (accept) begin
         state_rdata_ff <= state_mem_ff[in_index_ext[AW-1:0]];
      end
   end

   // Seen-this-frame memory.
   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem_ff[wr_addr] <= seen_wdata;
      end
      if (accept) begin
         seen_rdata_ff <= seen_mem_ff[in_index_ext[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tat_pkg::RSP_DATA_W'(rsp_tile_ff);

`ifndef NO_ASSERTIONS
   a_sweep_blocks_input: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !req_tready)
      else $error("word accepted during clearing sweep");

   a_sweep_stage_empty: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !s1_valid_ff)
      else $error("update stage busy during clearing sweep");

   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && ctrl.rsp_valid) |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten");

   a_forward_taken: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_adv && ctrl.state_we && (s1_addr_ff == in_index_ext[AW-1:0]))
      |=> fwd_state_hit_ff)
      else $error("same-tile record not forwarded");
`endif

endmodule
`default_nettype wire

// ===== hdl/tat_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Read-modify-write datapath for one command against one tile record.
module tat_update (
   input  wire logic [1:0]          command,
   input  wire logic [8:0]          tile_number,
   input  wire logic [7:0]          frame_total,
   input  wire logic [15:0]         step_increment,
   input  wire logic [15:0]         frame_period,
   input  wire logic                play_once,
   input  wire logic                in_range,
   input  wire tat_pkg::entry_type  entry_in,
   input  wire logic                seen_in,
   output tat_pkg::entry_type       entry_out,
   output tat_pkg::upd_ctrl_type    ctrl,
   output logic [8:0]               shown_tile
);

   logic                        animated;
   logic [tat_pkg::TIMER_W:0]   timer_sum;
   logic [tat_pkg::TIMER_W-1:0] timer_step;
   logic                        fire;
   logic [8:0]                  offset_inc;
   logic [7:0]                  offset_next;
   logic [1:0]                  mode_next;

   assign animated = in_range && (entry_in.frame_limit != 8'd0);

   always_comb begin
      timer_sum = {1'b0, entry_in.timer} + (tat_pkg::TIMER_W + 1)'(entry_in.increment);
      if (seen_in) begin
         timer_step = entry_in.timer;
      end else if (timer_sum[tat_pkg::TIMER_W]) begin
         timer_step = tat_pkg::TIMER_MAX;
      end else begin
         timer_step = timer_sum[tat_pkg::TIMER_W-1:0];
      end

      fire = (timer_step >= {1'b0, entry_in.period}) &&
             (entry_in.mode != tat_pkg::MODE_STOPPED);

      offset_inc  = {1'b0, entry_in.offset} + 9'd1;
      offset_next = entry_in.offset;
      mode_next   = entry_in.mode;
      if (fire) begin
         if (offset_inc > {1'b0, entry_in.frame_limit}) begin
            if (entry_in.mode == tat_pkg::MODE_ONCE) begin
               // A one-shot animation parks on its last frame.
               mode_next   = tat_pkg::MODE_STOPPED;
               offset_next = entry_in.frame_limit;
            end else begin
               offset_next = 8'd0;
            end
         end else begin
            offset_next = offset_inc[7:0];
         end
      end
   end

   always_comb begin
      entry_out  = entry_in;
      ctrl       = '0;
      shown_tile = tile_number;
      unique case (command)
         tat_pkg::CMD_SET: begin
            entry_out.frame_limit = frame_total;
            entry_out.increment   = step_increment;
            entry_out.period      = frame_period;
            entry_out.timer       = '0;
            entry_out.offset      = 8'd0;
            entry_out.mode        = play_once ? tat_pkg::MODE_ONCE : tat_pkg::MODE_LOOP;
            ctrl.state_we         = in_range;
         end
         tat_pkg::CMD_LOOKUP: begin
            ctrl.rsp_valid = 1'b1;
            if (animated) begin
               entry_out.timer  = fire ? '0 : timer_step;
               entry_out.offset = offset_next;
               entry_out.mode   = mode_next;
               ctrl.state_we    = 1'b1;
               ctrl.seen_we     = 1'b1;
               shown_tile       = tile_number + {1'b0, offset_next};
            end
         end
         tat_pkg::CMD_NEWFRAME, tat_pkg::CMD_NONE: begin
            ctrl = '0;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule
`default_nettype wire
